/* src/rrts_pkg.sv */
// Package for the round-robin time-slice scheduler.
// Holds table sizes, request and status codes. No dependencies.
package rrts_pkg;
  localparam int MaxTasks  = 1024;
  localparam int IdBits    = 10;
  localparam int SliceBits = 16;
  localparam int ChunkBits = 64;
  localparam int NumChunks = MaxTasks / ChunkBits;
  localparam int ChunkIdx  = $clog2(NumChunks);
  localparam int OffBits   = $clog2(ChunkBits);

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_CREATE = 2'd1;
  localparam logic [1:0] REQ_KILL   = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_SWITCHED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DISABLED = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_CREATED  = 3'd5;

  typedef logic [IdBits-1:0] id_t;
  typedef logic [SliceBits-1:0] slice_t;
endpackage

/* src/round_robin_timeslice_scheduler.sv */
// Round-robin time-slice scheduler: task table in memories, alive map in flops.
// A search walks the alive map one 64-bit chunk per cycle through one shared
// priority finder (up to 17 chunks). One item in flight at a time; in_stall
// stays high until the result is taken, so a new request is accepted only
// after the previous result beat has been taken.
// rst is synchronous: clears alive map, current task and enable; the context
// memories are not cleared and are only read for slots already created.
// Depends on rrts_pkg.
module round_robin_timeslice_scheduler (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [9:0]           task_id,
  input  logic [15:0]          slice_prio,
  input  logic [31:0]          sp_value,
  input  logic [31:0]          usp_value,
  input  logic [31:0]          base_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic                 cur_valid,
  output logic [9:0]           cur_id,
  output logic [31:0]          next_sp,
  output logic [31:0]          next_usp,
  output logic [31:0]          next_base
);
  import rrts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDCUR = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RDNXT = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic       enable;
  logic [MaxTasks-1:0] alive;
  id_t        running_id;
  logic       running_valid;

  // captured request
  slice_t     r_prio;
  logic [31:0] r_sp, r_usp, r_base;
  logic [ChunkIdx:0] chunk_cnt;
  logic        scan_free;
  id_t         start_id;
  id_t         found_id;

  // context memories
  slice_t      mem_len  [MaxTasks];
  slice_t      mem_left [MaxTasks];
  logic [31:0] mem_sp   [MaxTasks];
  logic [31:0] mem_usp  [MaxTasks];
  logic [31:0] mem_base [MaxTasks];
  id_t         rd_addr;
  slice_t      rd_len, rd_left;
  logic [31:0] rd_sp, rd_usp, rd_base;

  // write port control
  logic   we_len, we_left, we_ctx, we_base;
  id_t    wr_addr;
  slice_t wr_len, wr_left;
  logic [31:0] wr_sp, wr_usp, wr_base;

  always_ff @(posedge clk) begin
    if (we_len)  mem_len[wr_addr]  <= wr_len;
    if (we_left) mem_left[wr_addr] <= wr_left;
    if (we_ctx) begin
      mem_sp[wr_addr]  <= wr_sp;
      mem_usp[wr_addr] <= wr_usp;
    end
    if (we_base) mem_base[wr_addr] <= wr_base;
    rd_len  <= mem_len[rd_addr];
    rd_left <= mem_left[rd_addr];
    rd_sp   <= mem_sp[rd_addr];
    rd_usp  <= mem_usp[rd_addr];
    rd_base <= mem_base[rd_addr];
  end

  // shared chunk finder: lowest set bit of a masked 64-bit slice
  logic [ChunkIdx-1:0] cur_chunk;
  logic [ChunkBits-1:0] chunk_bits, chunk_mask;
  logic                 hit;
  logic [OffBits-1:0]   hit_off;
  logic [ChunkIdx:0]    scan_pos;

  always_comb begin
    scan_pos  = {1'b0, start_id[IdBits-1 -: ChunkIdx]} + chunk_cnt;
    cur_chunk = scan_pos[ChunkIdx-1:0];
    chunk_bits = alive[cur_chunk*ChunkBits +: ChunkBits];
    if (scan_free) chunk_bits = ~chunk_bits;
    chunk_mask = '1;
    // first chunk: start after current slot; last pass: up to and incl. it
    if (!scan_free) begin
      if (chunk_cnt == '0)
        chunk_mask = ~(({ChunkBits{1'b0}} | 1'b1) << start_id[OffBits-1:0]) &
                     ~((({ChunkBits{1'b0}} | 1'b1) << start_id[OffBits-1:0]) - 1'b1);
      else if (chunk_cnt == (ChunkIdx+1)'(NumChunks))
        chunk_mask = ((({ChunkBits{1'b0}} | 1'b1) << start_id[OffBits-1:0]) << 1) - 1'b1;
    end
    chunk_bits = chunk_bits & chunk_mask;
    hit = |chunk_bits;
    hit_off = '0;
    for (int i = ChunkBits-1; i >= 0; i--)
      if (chunk_bits[i]) hit_off = OffBits'(i);
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    we_len = 1'b0; we_left = 1'b0; we_ctx = 1'b0; we_base = 1'b0;
    wr_addr = running_id; wr_len = r_prio; wr_left = '0;
    wr_sp = r_sp; wr_usp = r_usp; wr_base = r_base;
    rd_addr = running_id;
    if (state == S_RDNXT || state == S_LOAD) rd_addr = found_id;
    if (state == S_CHK) begin
      if (rd_left != '0 && alive[running_id]) begin
        we_left = 1'b1; wr_left = rd_left - 1'b1;
      end else begin
        we_left = 1'b1; wr_left = rd_len; we_ctx = 1'b1;
      end
    end
    if (state == S_SCAN && scan_free && hit) begin
      wr_addr = {cur_chunk, hit_off};
      we_len = 1'b1; we_left = 1'b1; we_ctx = 1'b1; we_base = 1'b1;
    end
    if (state == S_LOAD) begin
      wr_addr = found_id; we_left = 1'b1; wr_left = rd_len;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; enable <= 1'b0; alive <= '0;
      running_id <= '0; running_valid <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) enable <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_prio <= slice_prio;
            r_sp <= sp_value; r_usp <= usp_value; r_base <= base_value;
            next_sp <= '0; next_usp <= '0; next_base <= '0;
            status <= ST_DONE; cur_id <= running_valid ? running_id : '0;
            cur_valid <= running_valid;
            chunk_cnt <= '0;
            case (req_type)
              REQ_TICK: begin
                if (!enable) begin
                  status <= ST_DISABLED; state <= S_OUT;
                end else if (!running_valid) begin
                  if (alive[0]) begin
                    found_id <= '0; state <= S_RDNXT;
                  end else begin
                    status <= ST_NONE; state <= S_OUT;
                  end
                end else state <= S_RDCUR;
              end
              REQ_CREATE: begin
                scan_free <= 1'b1; start_id <= '0; state <= S_SCAN;
              end
              REQ_KILL: begin
                alive[task_id] <= 1'b0; state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_RDCUR: state <= S_CHK;
        S_CHK: begin
          if (rd_left != '0 && alive[running_id]) state <= S_OUT;
          else begin
            scan_free <= 1'b0; start_id <= running_id; state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (scan_free) begin
              alive[{cur_chunk, hit_off}] <= 1'b1;
              cur_id <= {cur_chunk, hit_off}; status <= ST_CREATED;
              state <= S_OUT;
            end else begin
              found_id <= {cur_chunk, hit_off}; state <= S_RDNXT;
            end
          end else if (chunk_cnt == (scan_free ? (ChunkIdx+1)'(NumChunks-1)
                                                : (ChunkIdx+1)'(NumChunks))) begin
            status <= scan_free ? ST_FULL : ST_NONE; state <= S_OUT;
          end else chunk_cnt <= chunk_cnt + 1'b1;
        end
        S_RDNXT: state <= S_LOAD;
        S_LOAD: begin
          running_id <= found_id; running_valid <= 1'b1;
          cur_id <= found_id; cur_valid <= 1'b1; status <= ST_SWITCHED;
          next_sp <= rd_sp; next_usp <= rd_usp; next_base <= rd_base;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* bench/round_robin_timeslice_scheduler_chk.sv */
// Checker for the round-robin time-slice scheduler: mirrors the task table,
// predicts one result beat per request beat and compares in order.
// Depends on rrts_pkg.
module round_robin_timeslice_scheduler_chk
  import rrts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [9:0]  task_id,
  input  logic [15:0] slice_prio,
  input  logic [31:0] sp_value,
  input  logic [31:0] usp_value,
  input  logic [31:0] base_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic        cur_valid,
  input  logic [9:0]  cur_id,
  input  logic [31:0] next_sp,
  input  logic [31:0] next_usp,
  input  logic [31:0] next_base,
  output int          errors,
  output int          pending,
  output int          switches,
  output int          results
);

  typedef struct packed {
    logic [2:0]  status;
    logic        cur_valid;
    logic [9:0]  cur_id;
    logic [31:0] sp;
    logic [31:0] usp;
    logic [31:0] base;
  } sched_result_t;

  // Mirror of the task table
  logic        alive_map [MaxTasks];
  slice_t      slice_len [MaxTasks];
  slice_t      slice_left [MaxTasks];
  logic [31:0] ctx_sp [MaxTasks];
  logic [31:0] ctx_usp [MaxTasks];
  logic [31:0] ctx_base [MaxTasks];
  id_t         run_id;
  logic        run_valid;
  logic        sched_on;

  sched_result_t due_results[$];

  assign pending = due_results.size();

  initial begin
    errors = 0;
    switches = 0;
    results = 0;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH beat %0d %s: got %h want %h", results, field, got, want);
    errors++;
  endtask

  task automatic clear_table();
    for (int i = 0; i < MaxTasks; i++) alive_map[i] = 1'b0;
    run_id = '0;
    run_valid = 1'b0;
    sched_on = 1'b0;
  endtask

  // Report the saved context of a slot that becomes current
  function automatic void load_context(inout sched_result_t r, input int slot);
    r.status = ST_SWITCHED;
    r.sp = ctx_sp[slot];
    r.usp = ctx_usp[slot];
    r.base = ctx_base[slot];
  endfunction

  // Compute the result of one request beat and update the mirror
  function automatic sched_result_t predict_schedule(logic [1:0] req, id_t kid, slice_t prio,
                                                      logic [31:0] sp, logic [31:0] usp,
                                                      logic [31:0] base);
    sched_result_t r;
    int p;
    int idx;
    int slot;
    logic found;
    logic made;
    r = '0;
    made = 1'b0;
    slot = 0;
    found = 1'b0;
    if (req == REQ_TICK) begin
      if (!sched_on) begin
        r.status = ST_DISABLED;
      end else if (!run_valid) begin
        if (alive_map[0]) begin
          slice_left[0] = slice_len[0];
          run_id = '0;
          run_valid = 1'b1;
          load_context(r, 0);
        end else begin
          r.status = ST_NONE;
        end
      end else begin
        p = run_id;
        if (slice_left[p] != 0 && alive_map[p]) begin
          slice_left[p] = slice_left[p] - 1'b1;
          r.status = ST_DONE;
        end else begin
          // save the outgoing context, then search cyclically ending at p
          ctx_sp[p] = sp;
          ctx_usp[p] = usp;
          slice_left[p] = slice_len[p];
          idx = p;
          for (int k = 1; k <= MaxTasks && !found; k++) begin
            idx = (p + k) % MaxTasks;
            found = alive_map[idx];
          end
          if (found) begin
            slice_left[idx] = slice_len[idx];
            run_id = id_t'(idx);
            load_context(r, idx);
          end else begin
            r.status = ST_NONE;
          end
        end
      end
    end else if (req == REQ_CREATE) begin
      while (slot < MaxTasks && alive_map[slot]) slot++;
      if (slot >= MaxTasks) begin
        r.status = ST_FULL;
      end else begin
        alive_map[slot] = 1'b1;
        slice_len[slot] = prio;
        slice_left[slot] = '0;
        ctx_sp[slot] = sp;
        ctx_usp[slot] = usp;
        ctx_base[slot] = base;
        made = 1'b1;
        r.status = ST_CREATED;
      end
    end else if (req == REQ_KILL) begin
      alive_map[kid] = 1'b0;
      r.status = ST_DONE;
    end
    r.cur_valid = run_valid;
    if (made) r.cur_id = id_t'(slot);
    else r.cur_id = run_valid ? run_id : '0;
    return r;
  endfunction

  // Track reset, register writes, request beats and result beats
  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      clear_table();
      due_results.delete();
    end else begin
      if (cfg_we) sched_on = cfg_wdata;
      if (in_valid && !in_stall)
        due_results.push_back(predict_schedule(req_type, task_id, slice_prio, sp_value,
                                               usp_value, base_value));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("MISMATCH unexpected result beat, status %0d", status);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (status != want.status) report_mismatch("status", status, want.status);
          if (cur_valid != want.cur_valid)
            report_mismatch("cur_valid", cur_valid, want.cur_valid);
          if (cur_id != want.cur_id) report_mismatch("cur_id", cur_id, want.cur_id);
          if (next_sp != want.sp) report_mismatch("next_sp", next_sp, want.sp);
          if (next_usp != want.usp) report_mismatch("next_usp", next_usp, want.usp);
          if (next_base != want.base) report_mismatch("next_base", next_base, want.base);
          if (want.status == ST_SWITCHED) switches++;
        end
        results++;
      end
    end
  end

endmodule

/* bench/round_robin_timeslice_scheduler_tb.sv */
// Testbench top for the round-robin time-slice scheduler: drives requests,
// register writes and result back-pressure, and gives the verdict.
// Depends on rrts_pkg, round_robin_timeslice_scheduler and its checker.
module round_robin_timeslice_scheduler_tb;
  import rrts_pkg::*;

  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam int SettleCycles = NumChunks + 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [9:0]  task_id = '0;
  logic [15:0] slice_prio = '0;
  logic [31:0] sp_value = '0;
  logic [31:0] usp_value = '0;
  logic [31:0] base_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        cur_valid;
  logic [9:0]  cur_id;
  logic [31:0] next_sp;
  logic [31:0] next_usp;
  logic [31:0] next_base;

  int errors;
  int pending;
  int switches;
  int results;
  int sent = 0;
  logic hold_results = 1'b0;

  always #1 clk = ~clk;

  round_robin_timeslice_scheduler i_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .req_type, .task_id,
    .slice_prio, .sp_value, .usp_value, .base_value, .out_valid, .out_stall,
    .status, .cur_valid, .cur_id, .next_sp, .next_usp, .next_base
  );

  round_robin_timeslice_scheduler_chk i_chk (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .req_type, .task_id,
    .slice_prio, .sp_value, .usp_value, .base_value, .out_valid, .out_stall,
    .status, .cur_valid, .cur_id, .next_sp, .next_usp, .next_base,
    .errors, .pending, .switches, .results
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request beat and hold it until accepted
  task automatic offer(logic [1:0] req, logic [9:0] kid, logic [15:0] prio,
                       logic [31:0] sp, logic [31:0] usp, logic [31:0] base);
    int gap;
    req_type = req;
    task_id = kid;
    slice_prio = prio;
    sp_value = sp;
    usp_value = usp;
    base_value = base;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
    gap = (sent % 200 < 40) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain every outstanding result, let the block settle, then write
  task automatic write_enable(logic value);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_request(int create_pct);
    int r;
    logic [15:0] prio;
    logic [9:0] kid;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: prio = 16'($urandom);
      1, 2: prio = 16'($urandom_range(4, 20));
      default: prio = 16'($urandom_range(0, 3));
    endcase
    kid = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 12)) : 10'($urandom);
    if (r < create_pct)
      offer(REQ_CREATE, 10'($urandom), prio, $urandom, $urandom, $urandom);
    else if (r < create_pct + 15)
      offer(REQ_KILL, kid, 16'($urandom), $urandom, $urandom, $urandom);
    else if (r < create_pct + 20)
      offer(REQ_UNDEF, 10'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
    else
      offer(REQ_TICK, 10'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Result back-pressure, with one long hold-off requested by the sender
  initial begin
    int cnt;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_stall = 1'b1;
        for (cnt = 0; cnt < 300; cnt++) @(negedge clk);
        hold_results = 1'b0;
        out_stall = 1'b0;
      end else if ((cnt++ % 300) < 60) begin
        out_stall = 1'b0;
      end else begin
        out_stall = pick_gap() > 0;
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Scheduling off after reset
    offer(REQ_TICK, '0, '0, '0, '0, '0);
    offer(REQ_UNDEF, 10'h3FF, 16'hFFFF, '1, '1, '1);
    write_enable(1'b1);

    // Start with nothing alive, then build three tasks
    offer(REQ_TICK, '0, '0, 32'h1, 32'h2, '0);
    offer(REQ_KILL, 10'h3FF, '0, '0, '0, '0);
    offer(REQ_CREATE, '0, 16'h0000, '0, '0, '0);
    offer(REQ_CREATE, '0, 16'hFFFF, '1, '1, '1);
    offer(REQ_CREATE, '0, 16'h0002, 32'hA5A5_0001, 32'h5A5A_0002, 32'hC0DE_0003);
    offer(REQ_TICK, '0, '0, 32'h1111, 32'h2222, '0);
    offer(REQ_TICK, '0, '0, 32'h3333, 32'h4444, '0);
    offer(REQ_TICK, '0, '0, 32'h5555, 32'h6666, '0);
    // Kill the current task, then switch away from it
    offer(REQ_KILL, 10'd1, '0, '0, '0, '0);
    offer(REQ_TICK, '0, '0, 32'h7777, 32'h8888, '0);
    // Nothing alive on switch keeps the current slot
    offer(REQ_KILL, 10'd0, '0, '0, '0, '0);
    offer(REQ_KILL, 10'd2, '0, '0, '0, '0);
    offer(REQ_TICK, '0, '0, 32'h9999, 32'hAAAA, '0);
    offer(REQ_TICK, '0, '0, 32'hBBBB, 32'hCCCC, '0);
    // Create into the lowest dead slot, then wrap round to it
    offer(REQ_CREATE, '0, 16'h0001, 32'hDEAD_0000, 32'hBEEF_0000, 32'hFACE_0000);
    offer(REQ_TICK, '0, '0, 32'hDDDD, 32'hEEEE, '0);
    offer(REQ_TICK, '0, '0, 32'h0F0F, 32'hF0F0, '0);

    // Random request mix with one long result hold-off
    for (int i = 0; i < 250; i++) begin
      if (i == 100) hold_results = 1'b1;
      random_request(20);
    end

    // Sender pauses until every result has come back
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (5) @(negedge clk);

    write_enable(1'b0);
    for (int i = 0; i < 30; i++) random_request(30);
    write_enable(1'b1);
    for (int i = 0; i < 200; i++) random_request(20);

    // Fill the table, overflow it, and schedule across it
    for (int i = 0; i < 1030; i++)
      offer(REQ_CREATE, 10'($urandom), 16'($urandom_range(0, 1)), $urandom, $urandom,
            $urandom);
    for (int i = 0; i < 60; i++) random_request(10);

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk);
    $display("covered %0d request beats, %0d result beats, %0d task switches",
             sent, results, switches);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rrts_pkg.sv
src/round_robin_timeslice_scheduler.sv
bench/round_robin_timeslice_scheduler_chk.sv
bench/round_robin_timeslice_scheduler_tb.sv
